### hw/rtl/orp_wbc_pkg.sv
package orp_wbc_pkg;

  // Default ring depth.
  localparam int unsigned MAX_SAMPLES_DEF = 64;

  // Register reset values.
  localparam logic [6:0]  WINDOW_RST = 7'd60;
  localparam logic [13:0] LIMIT_RST  = 14'd320;
  localparam logic [11:0] TARGET_RST = 12'd700;
  localparam logic [9:0]  HYST_RST   = 10'd10;
  localparam logic [8:0]  IVAL_RST   = 9'd10;
  localparam logic [39:0] PCT_RST    = 40'h64503C2814;

  // Milliseconds per window slot.
  localparam logic [31:0] MS_PER_SLOT = 32'd1000;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_WINDOW = 3'd0,
    REG_LIMIT  = 3'd1,
    REG_TARGET = 3'd2,
    REG_HYST   = 3'd3,
    REG_IVAL   = 3'd4,
    REG_PCT    = 3'd5
  } cfg_idx_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_STORED = 3'd0,
    ST_FEW    = 3'd1,
    ST_SPREAD = 3'd2,
    ST_OFF    = 3'd3,
    ST_LOW    = 3'd4,
    ST_GEN    = 3'd5
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic add_wr;
    logic q_init;
    logic scan_init;
    logic scan_en;
    logic pass2;
    logic div_init;
    logic div_step;
    logic set_mean;
    logic set_few;
    logic mul_lim;
    logic mul_thr;
    logic cmp_spread;
    logic decide;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
    logic pipe_busy;
    logic too_few;
    logic div_done;
  } sts_t;

endpackage

### hw/rtl/orp_wbc_ram.sv
module orp_wbc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/orp_wbc_ctrl.sv
module orp_wbc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_op_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  orp_wbc_pkg::sts_t  sts_i,
  output orp_wbc_pkg::cmd_t  cmd_o
);

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_ADD    = 15'b000000000000010,
    S_QINIT  = 15'b000000000000100,
    S_SCAN1  = 15'b000000000001000,
    S_DRAIN1 = 15'b000000000010000,
    S_CHECK  = 15'b000000000100000,
    S_DIV    = 15'b000000001000000,
    S_MEAN   = 15'b000000010000000,
    S_SCAN2  = 15'b000000100000000,
    S_DRAIN2 = 15'b000001000000000,
    S_LIM    = 15'b000010000000000,
    S_THR    = 15'b000100000000000,
    S_CMP    = 15'b001000000000000,
    S_DECIDE = 15'b010000000000000,
    S_DONE   = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // Sequencing of one word through the datapath.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = in_op_i ? S_QINIT : S_ADD;
        end
      end
      S_ADD: begin
        cmd_o.add_wr = 1'b1;
        state_d      = S_DONE;
      end
      S_QINIT: begin
        cmd_o.q_init    = 1'b1;
        cmd_o.scan_init = 1'b1;
        state_d         = S_SCAN1;
      end
      S_SCAN1: begin
        cmd_o.scan_en = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_DRAIN1;
        end
      end
      S_DRAIN1: begin
        if (!sts_i.pipe_busy) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.too_few) begin
          cmd_o.set_few = 1'b1;
          state_d       = S_DONE;
        end else begin
          cmd_o.div_init = 1'b1;
          state_d        = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = S_MEAN;
        end
      end
      S_MEAN: begin
        cmd_o.set_mean  = 1'b1;
        cmd_o.scan_init = 1'b1;
        state_d         = S_SCAN2;
      end
      S_SCAN2: begin
        cmd_o.scan_en = 1'b1;
        cmd_o.pass2   = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_DRAIN2;
        end
      end
      S_DRAIN2: begin
        if (!sts_i.pipe_busy) begin
          state_d = S_LIM;
        end
      end
      S_LIM: begin
        cmd_o.mul_lim = 1'b1;
        state_d       = S_THR;
      end
      S_THR: begin
        cmd_o.mul_thr = 1'b1;
        state_d       = S_CMP;
      end
      S_CMP: begin
        cmd_o.cmp_spread = 1'b1;
        state_d          = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // The output word stays until the receiver takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### hw/rtl/orp_wbc_dp.sv
module orp_wbc_dp #(
  parameter int unsigned MAX_SAMPLES = orp_wbc_pkg::MAX_SAMPLES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [39:0]        cfg_data_i,
  input  logic [11:0]        in_sample_i,
  input  logic [31:0]        in_now_i,
  input  orp_wbc_pkg::cmd_t  cmd_i,
  output orp_wbc_pkg::sts_t  sts_o,
  output logic [2:0]         out_status_o,
  output logic [7:0]         out_pct_o,
  output logic [2:0]         out_band_o,
  output logic               out_alarm_o,
  output logic [11:0]        out_mean_o
);

  localparam int unsigned AW   = $clog2(MAX_SAMPLES);
  localparam int unsigned CW   = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SW   = 12 + CW;
  localparam int unsigned DV   = SW + 8;
  localparam int unsigned DCW  = $clog2(DV + 1);
  localparam int unsigned SDW  = 42 + CW;
  localparam int unsigned TW   = 36 + CW;

  // Configuration and kept state.
  logic [6:0]        win_q;
  logic [13:0]       lim_q;
  logic [11:0]       tgt_q;
  logic [9:0]        hys_q;
  logic [8:0]        iv_q;
  logic [39:0]       pct_q;
  logic [MAX_SAMPLES-1:0] vld_q;
  logic [AW-1:0]     ws_q;
  logic [2:0]        band_q;
  logic              alarm_q;

  // Working registers.
  logic [11:0]       smp_q;
  logic [31:0]       now_q;
  logic [31:0]       agelim_q;
  logic [CW-1:0]     cnt_q;
  logic              v1_q, p1_q, v2_q, v3_q;
  logic [AW-1:0]     tag1_q;
  logic [20:0]       d_q;
  logic [41:0]       sq_q;
  logic signed [SW-1:0] sum_q;
  logic [CW-1:0]     n_q;
  logic [SDW-1:0]    sdev_q;
  logic              neg_q;
  logic [DV-1:0]     dq_q;
  logic [CW-1:0]     rem_q;
  logic [DCW-1:0]    dcnt_q;
  logic [20:0]       m8_q;
  logic [11:0]       mean_q;
  logic [35:0]       lim2_q;
  logic [TW-1:0]     thr_q;
  logic              spread_q;
  orp_wbc_pkg::status_e res_status_q;
  logic [7:0]        res_pct_q;
  logic [11:0]       res_mean_q;
  logic [2:0]        out_status_q;
  logic [7:0]        out_pct_q;
  logic [2:0]        out_band_q;
  logic              out_alarm_q;
  logic [11:0]       out_mean_q;

  // Slot count, clamped to the ring depth.
  logic [CW-1:0] slots;
  always_comb begin
    if (win_q == 7'd0) begin
      slots = CW'(1);
    end else if (32'(win_q) > 32'(MAX_SAMPLES)) begin
      slots = CW'(MAX_SAMPLES);
    end else begin
      slots = CW'(win_q);
    end
  end

  // Write slot, restarted when the window shrank below it.
  logic [AW-1:0] ws_eff;
  logic [CW-1:0] ws_inc;
  logic [AW-1:0] ws_nxt;
  always_comb begin
    ws_eff = (CW'(ws_q) >= slots) ? '0 : ws_q;
    ws_inc = CW'(ws_eff) + CW'(1);
    ws_nxt = (ws_inc >= slots) ? '0 : ws_inc[AW-1:0];
  end

  // Sample ring: time stamp above the reading.
  logic [43:0] ram_rdata;
  logic [11:0] ram_smp;
  logic [31:0] ram_time;

  orp_wbc_ram #(
    .WIDTH (44),
    .DEPTH (MAX_SAMPLES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.add_wr),
    .waddr_i (ws_eff),
    .wdata_i ({now_q, smp_q}),
    .raddr_i (cnt_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign ram_smp  = ram_rdata[11:0];
  assign ram_time = ram_rdata[43:12];

  // Staleness of the slot now read.
  logic [31:0] age;
  logic        stale;
  logic        hit;
  assign age   = now_q - ram_time;
  assign stale = age > agelim_q;
  assign hit   = v1_q && vld_q[tag1_q];

  // Absolute deviation of the read sample from the Q8 mean.
  logic [21:0] diff;
  logic [21:0] diff_neg;
  logic [20:0] ad;
  always_comb begin
    diff     = {{2{ram_smp[11]}}, ram_smp, 8'd0} - {m8_q[20], m8_q};
    diff_neg = ~diff + 22'd1;
    ad       = diff[21] ? diff_neg[20:0] : diff[20:0];
  end

  // Minimum count: three quarters of the slots, rounded down.
  logic [CW+1:0] s3;
  logic          few;
  always_comb begin
    s3  = {2'b00, slots} + {1'b0, slots, 1'b0};
    few = (n_q == '0) || (n_q < s3[CW+1:2]);
  end

  // One restoring division step.
  logic [CW:0] r2;
  logic [CW:0] r2_sub;
  logic        r2_ge;
  always_comb begin
    r2     = {rem_q, dq_q[DV-1]};
    r2_sub = r2 - {1'b0, n_q};
    r2_ge  = r2 >= {1'b0, n_q};
  end

  // Band edges in Q8.
  logic signed [23:0] tg24, base24, t8, base8, b1, low8, m8x;
  logic [23:0]        hys24, iv24;
  logic signed [23:0] lo_a [2:5];
  logic signed [23:0] hi_a [2:5];
  logic [2:0]         chosen;
  logic [7:0]         pct_sel;
  always_comb begin
    tg24   = {{12{tgt_q[11]}}, tgt_q};
    hys24  = {14'd0, hys_q};
    iv24   = {15'd0, iv_q};
    base24 = tg24 - hys24;
    t8     = tg24 <<< 8;
    base8  = base24 <<< 8;
    b1     = (base24 - iv24 + 24'sd1) <<< 8;
    low8   = (base24 - iv24 * 24'd5) <<< 8;
    m8x    = {{3{m8_q[20]}}, m8_q};
    for (int k = 2; k <= 5; k++) begin
      lo_a[k] = (base24 - iv24 * 24'(k) + 24'sd1) <<< 8;
      hi_a[k] = (base24 - iv24 * 24'(k - 1)) <<< 8;
    end
    chosen = 3'd6;
    if (m8x >= b1) begin
      chosen = 3'd1;
    end else begin
      for (int k = 2; k <= 5; k++) begin
        if (chosen == 3'd6 && m8x >= lo_a[k] && m8x <= hi_a[k]) begin
          chosen = 3'(k);
        end
      end
    end
    case (chosen)
      3'd1:    pct_sel = pct_q[7:0];
      3'd2:    pct_sel = pct_q[15:8];
      3'd3:    pct_sel = pct_q[23:16];
      3'd4:    pct_sel = pct_q[31:24];
      default: pct_sel = pct_q[39:32];
    endcase
  end

  // Configuration writes restart the window.
  logic restart;
  always_comb begin
    restart = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        orp_wbc_pkg::REG_WINDOW, orp_wbc_pkg::REG_LIMIT, orp_wbc_pkg::REG_TARGET,
        orp_wbc_pkg::REG_HYST, orp_wbc_pkg::REG_IVAL, orp_wbc_pkg::REG_PCT: begin
          restart = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= orp_wbc_pkg::WINDOW_RST;
      lim_q <= orp_wbc_pkg::LIMIT_RST;
      tgt_q <= orp_wbc_pkg::TARGET_RST;
      hys_q <= orp_wbc_pkg::HYST_RST;
      iv_q  <= orp_wbc_pkg::IVAL_RST;
      pct_q <= orp_wbc_pkg::PCT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        orp_wbc_pkg::REG_WINDOW: win_q <= cfg_data_i[6:0];
        orp_wbc_pkg::REG_LIMIT:  lim_q <= cfg_data_i[13:0];
        orp_wbc_pkg::REG_TARGET: tgt_q <= cfg_data_i[11:0];
        orp_wbc_pkg::REG_HYST:   hys_q <= cfg_data_i[9:0];
        orp_wbc_pkg::REG_IVAL:   iv_q  <= cfg_data_i[8:0];
        orp_wbc_pkg::REG_PCT:    pct_q <= cfg_data_i[39:0];
        default: begin
        end
      endcase
    end
  end

  // Valid marks, write slot, band state and alarm.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      ws_q    <= '0;
      band_q  <= 3'd0;
      alarm_q <= 1'b0;
    end else if (restart) begin
      vld_q  <= '0;
      ws_q   <= '0;
      band_q <= 3'd0;
    end else begin
      if (cmd_i.add_wr) begin
        vld_q[ws_eff] <= 1'b1;
        ws_q          <= ws_nxt;
      end
      if (hit && !p1_q && stale) begin
        vld_q[tag1_q] <= 1'b0;
      end
      if (cmd_i.decide) begin
        if (spread_q) begin
          alarm_q <= 1'b1;
        end else if ((band_q != 3'd0 && m8x > t8) || (band_q == 3'd0 && m8x >= base8)) begin
          alarm_q <= 1'b0;
          band_q  <= 3'd0;
        end else if (m8x < low8) begin
          alarm_q <= 1'b1;
          band_q  <= 3'd0;
        end else begin
          alarm_q <= 1'b0;
          band_q  <= chosen;
        end
      end
    end
  end

  // Scan counter and read pipeline valids.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
    end else begin
      if (cmd_i.scan_init) begin
        cnt_q <= '0;
      end else if (cmd_i.scan_en) begin
        cnt_q <= cnt_q + CW'(1);
      end
      v1_q <= cmd_i.scan_en;
      v2_q <= hit && p1_q;
      v3_q <= v2_q;
    end
  end

  // Accumulation, division and threshold arithmetic.
  always_ff @(posedge clk_i) begin
    p1_q   <= cmd_i.pass2;
    tag1_q <= cnt_q[AW-1:0];
    d_q    <= ad;
    sq_q   <= d_q * d_q;
    if (cmd_i.load) begin
      smp_q    <= in_sample_i;
      now_q    <= in_now_i;
      agelim_q <= 32'(slots) * orp_wbc_pkg::MS_PER_SLOT;
    end
    if (cmd_i.q_init) begin
      sum_q  <= '0;
      n_q    <= '0;
      sdev_q <= '0;
    end else begin
      if (hit && !p1_q && !stale) begin
        sum_q <= sum_q + {{CW{ram_smp[11]}}, ram_smp};
        n_q   <= n_q + CW'(1);
      end
      if (v3_q) begin
        sdev_q <= sdev_q + SDW'(sq_q);
      end
    end
    if (cmd_i.div_init) begin
      neg_q  <= sum_q[SW-1];
      dq_q   <= {(sum_q[SW-1] ? (~sum_q + SW'(1)) : sum_q), 8'd0};
      rem_q  <= '0;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= r2_ge ? r2_sub[CW-1:0] : r2[CW-1:0];
      dq_q   <= {dq_q[DV-2:0], r2_ge};
      dcnt_q <= dcnt_q + DCW'(1);
    end
    if (cmd_i.set_mean) begin
      m8_q   <= neg_q ? (~{1'b0, dq_q[19:0]} + 21'd1) : {1'b0, dq_q[19:0]};
      mean_q <= neg_q ? (~dq_q[19:8] + 12'd1) : dq_q[19:8];
    end
    if (cmd_i.mul_lim) begin
      lim2_q <= {lim_q, 4'd0} * {lim_q, 4'd0};
    end
    if (cmd_i.mul_thr) begin
      thr_q <= lim2_q * n_q;
    end
    if (cmd_i.cmp_spread) begin
      spread_q <= sdev_q > SDW'(thr_q);
    end
  end

  // Result fields of the current word.
  always_ff @(posedge clk_i) begin
    if (cmd_i.add_wr) begin
      res_status_q <= orp_wbc_pkg::ST_STORED;
      res_pct_q    <= 8'd0;
      res_mean_q   <= 12'd0;
    end else if (cmd_i.set_few) begin
      res_status_q <= orp_wbc_pkg::ST_FEW;
      res_pct_q    <= 8'd0;
      res_mean_q   <= 12'd0;
    end else if (cmd_i.decide) begin
      res_mean_q <= mean_q;
      res_pct_q  <= 8'd0;
      if (spread_q) begin
        res_status_q <= orp_wbc_pkg::ST_SPREAD;
      end else if ((band_q != 3'd0 && m8x > t8) || (band_q == 3'd0 && m8x >= base8)) begin
        res_status_q <= orp_wbc_pkg::ST_OFF;
      end else if (m8x < low8) begin
        res_status_q <= orp_wbc_pkg::ST_LOW;
      end else begin
        res_status_q <= orp_wbc_pkg::ST_GEN;
        res_pct_q    <= pct_sel;
      end
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_pct_q    <= res_pct_q;
      out_band_q   <= band_q;
      out_alarm_q  <= alarm_q;
      out_mean_q   <= res_mean_q;
    end
  end

  assign sts_o.scan_last = (cnt_q == slots - CW'(1));
  assign sts_o.pipe_busy = v1_q | v2_q | v3_q;
  assign sts_o.too_few   = few;
  assign sts_o.div_done  = (dcnt_q == DCW'(DV - 1));

  assign out_status_o = out_status_q;
  assign out_pct_o    = out_pct_q;
  assign out_band_o   = out_band_q;
  assign out_alarm_o  = out_alarm_q;
  assign out_mean_o   = out_mean_q;

endmodule

### hw/rtl/orp_window_band_controller_core.sv
// ORP window band controller.
// Input words arrive on the s_axis channel: tuser selects adding a timestamped
// sample or querying the generator setting, tdata carries the reading and time.
// Each word yields exactly one output word on m_axis: status in tuser, and the
// chosen percentage, band state, alarm flag and window mean in tdata.
// Settings are to be written through cfg_we_i/cfg_idx_i/cfg_data_i only while
// idle, which the block itself does not enforce; a write to any of the six
// settings empties the sample window and returns the band state to idle.
// One word is worked on at a time. An add writes its sample into the ring and
// then goes to the output. A query walks the ring twice through the read port
// of the sample memory, one slot per cycle, with a bit-serial divider run in
// between. A too-few query ends after the first walk.
// Reset clears the valid marks, write slot, band state, alarm flag and
// settings to their defaults; the memory itself needs no clearing.
// The result sits in an output register: when the receiver stalls, the next
// input word is still taken and worked on, and waits only at its own end.
module orp_window_band_controller_core #(
  parameter int unsigned MAX_SAMPLES = orp_wbc_pkg::MAX_SAMPLES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // [11:0] orp_sample, [43:12] now_ms, [47:44] zero
  input  logic [0:0]  s_axis_tuser,  // [0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [7:0] output_pct, [10:8] band, [11] alarm,
                                     // [23:12] mean_orp
  output logic [2:0]  m_axis_tuser,  // [2:0] status
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [39:0] cfg_data_i
);

  orp_wbc_pkg::cmd_t cmd;
  orp_wbc_pkg::sts_t sts;
  logic [2:0]  out_status;
  logic [7:0]  out_pct;
  logic [2:0]  out_band;
  logic        out_alarm;
  logic [11:0] out_mean;

  // Sequencer.
  orp_wbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_op_i     (s_axis_tuser[0]),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Sample ring and arithmetic.
  orp_wbc_dp #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_sample_i  (s_axis_tdata[11:0]),
    .in_now_i     (s_axis_tdata[43:12]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_status_o (out_status),
    .out_pct_o    (out_pct),
    .out_band_o   (out_band),
    .out_alarm_o  (out_alarm),
    .out_mean_o   (out_mean)
  );

  assign m_axis_tdata = {out_mean, out_alarm, out_band, out_pct};
  assign m_axis_tuser = out_status;

endmodule
